// ===== sv/mfi_pkg.sv =====
package mfi_pkg;

    localparam int DATA_W     = 16;
    localparam int FRAC_W     = 12;
    localparam int IDX_W      = 6;
    localparam int CNT_W      = 7;
    localparam int LC_W       = 3;
    localparam int PADDR_W    = 5;
    localparam int WDEPTH     = 12288;
    localparam int WADDR_W    = 14;
    localparam int BDEPTH     = 192;
    localparam int BADDR_W    = 8;
    localparam int ADEPTH     = 192;
    localparam int AADDR_W    = 8;
    localparam int EDEPTH     = 64;
    localparam int EXP_W      = 17;
    localparam int EXP_Y_W    = 17;
    localparam int SUM_W      = 23;
    localparam int DIVN_W     = 33;
    localparam int DIV_CNT_W  = 6;
    localparam int ACC_W      = 40;
    localparam int PROD_W     = 32;
    localparam int EXP_ZERO_N = 12;

    localparam logic [1:0] REQ_WEIGHT = 2'd0;
    localparam logic [1:0] REQ_BIAS   = 2'd1;
    localparam logic [1:0] REQ_INPUT  = 2'd2;
    localparam logic [1:0] LAYER_NONE = 2'd3;

    localparam logic [2:0] REG_LAYERS = 3'd0;
    localparam logic [2:0] REG_W0     = 3'd1;
    localparam logic [2:0] REG_W1     = 3'd2;
    localparam logic [2:0] REG_W2     = 3'd3;
    localparam logic [2:0] REG_W3     = 3'd4;

    localparam logic [1:0] BANK_IN = 2'd0;
    localparam logic [1:0] BANK_A  = 2'd1;
    localparam logic [1:0] BANK_B  = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE, S_BIAS, S_BIASW, S_MAC, S_DRAIN, S_ROUND, S_SIG0, S_SIGE, S_SIGD,
        S_OWR, S_NEXT, S_EXRD, S_EXW, S_EXE, S_DVRD, S_DVS, S_DVW, S_OUT
    } state_t;

    typedef struct packed {
        logic              start;
        logic [DIVN_W-1:0] num;
        logic [SUM_W-1:0]  den;
    } div_req_t;

    function automatic logic [EXP_W-1:0] exp_int(input logic [3:0] n);
        logic [EXP_W-1:0] r;
        case (n)
            4'd0:    r = 17'd65536;
            4'd1:    r = 17'd24109;
            4'd2:    r = 17'd8869;
            4'd3:    r = 17'd3263;
            4'd4:    r = 17'd1200;
            4'd5:    r = 17'd442;
            4'd6:    r = 17'd162;
            4'd7:    r = 17'd60;
            4'd8:    r = 17'd22;
            4'd9:    r = 17'd8;
            4'd10:   r = 17'd3;
            4'd11:   r = 17'd1;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

    function automatic logic [EXP_W-1:0] exp_frac(input logic [4:0] k);
        logic [EXP_W-1:0] r;
        case (k)
            5'd0:    r = 17'd65536;
            5'd1:    r = 17'd61565;
            5'd2:    r = 17'd57835;
            5'd3:    r = 17'd54331;
            5'd4:    r = 17'd51039;
            5'd5:    r = 17'd47947;
            5'd6:    r = 17'd45042;
            5'd7:    r = 17'd42313;
            5'd8:    r = 17'd39750;
            5'd9:    r = 17'd37341;
            5'd10:   r = 17'd35079;
            5'd11:   r = 17'd32954;
            5'd12:   r = 17'd30957;
            5'd13:   r = 17'd29081;
            5'd14:   r = 17'd27319;
            5'd15:   r = 17'd25664;
            5'd16:   r = 17'd24109;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/mfi_ram.sv =====
module mfi_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/mfi_divider.sv =====
module mfi_divider (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  mfi_pkg::div_req_t         req,
    output logic                      busy,
    output logic                      done,
    output logic [mfi_pkg::DIVN_W-1:0] quot
);
    import mfi_pkg::*;

    logic                 busy_reg, done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [SUM_W-1:0]     rem_reg, den_reg;
    logic [DIVN_W-1:0]    quo_reg;
    logic [SUM_W:0]       trial, diff;
    logic                 ge;

    always_comb begin
        trial = {rem_reg, quo_reg[DIVN_W-1]};
        ge    = trial >= {1'b0, den_reg};
        diff  = trial - {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIVN_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= '0;
            quo_reg <= req.num;
            den_reg <= req.den;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
            quo_reg <= {quo_reg[DIVN_W-2:0], ge};
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quo_reg;

endmodule

// ===== sv/mfi_expn.sv =====
module mfi_expn (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    input  logic [mfi_pkg::EXP_Y_W-1:0] y,
    output logic                        out_valid,
    output logic [mfi_pkg::EXP_W-1:0]   e
);
    import mfi_pkg::*;

    logic [4:0]       n;
    logic [3:0]       k;
    logic [7:0]       t;
    logic [EXP_W-1:0] fk, fk1, fdiff, f;
    logic [19:0]      ip;
    logic [11:0]      adj;
    logic             v1_reg, v2_reg, z_reg;
    logic [EXP_W-1:0] f_reg, e_reg;
    logic [3:0]       n_reg;
    logic [33:0]      m;
    logic [33:0]      mr;

    always_comb begin
        n     = y[16:12];
        k     = y[11:8];
        t     = y[7:0];
        fk    = exp_frac({1'b0, k});
        fk1   = exp_frac({1'b0, k} + 5'd1);
        fdiff = fk - fk1;
        ip    = fdiff[11:0] * t;
        adj   = 12'((ip + 20'd128) >> 8);
        f     = fk - {5'd0, adj};
        m     = exp_int(n_reg) * f_reg;
        mr    = (m + 34'd32768) >> 16;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        f_reg <= f;
        n_reg <= n[3:0];
        z_reg <= n >= 5'(EXP_ZERO_N);
        e_reg <= z_reg ? '0 : mr[EXP_W-1:0];
    end

    assign out_valid = v2_reg;
    assign e         = e_reg;

endmodule

// ===== sv/mlp_forward_inference_unit.sv =====
// Fully connected network inference, Q4.12 activations, Q0.16 softmax output.
// Input stream s_*: tuser selects the request (weight, bias, input element);
// tdata carries layer, source, destination and value; tlast on an input
// element starts the forward pass. Load requests are taken one per cycle.
// Output stream m_*: one probability per output neuron, tlast on the final.
// During a pass s_tready is low. Per neuron the shared multiply-accumulate
// runs over the previous layer's width; a hidden neuron then takes the sigmoid
// through the exp unit and the serial divider (one quotient bit per cycle,
// 33 bits). Softmax runs an exp pass over all outputs, then one division per
// output.
// A stalled receiver holds the output register; the sequencer waits on it.
// Reset (synchronous, active low) restores the default layer sizes and
// returns to idle; weight, bias and activation memories are not cleared
// and must be written before use. Configuration is via the APB port.
module mlp_forward_inference_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mfi_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // layer_sel[1:0], src_index[7:2], dst_index[13:8], value[29:14]
    input  logic [31:0]                  s_tdata,
    // req_type[1:0]
    input  logic [1:0]                   s_tuser,
    input  logic                         s_tlast,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // out_index[5:0], probability[21:6]
    output logic [23:0]                  m_tdata,
    output logic                         m_tlast
);
    import mfi_pkg::*;

    logic [LC_W-1:0]  lc_reg;
    logic [CNT_W-1:0] w0_reg, w1_reg, w2_reg, w3_reg;

    state_t             state_reg, state_next;
    logic [LC_W-1:0]    l_reg, l_next;
    logic [IDX_W-1:0]   j_reg, j_next, i_reg, i_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic               rd_v_reg, mul_v_reg;
    logic [DATA_W-1:0]  q_reg, q_next, mx_reg, mx_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [DATA_W-1:0]  p_reg, p_next;
    logic               m_valid_reg, m_last_reg;
    logic [IDX_W-1:0]   m_idx_reg;
    logic [DATA_W-1:0]  m_p_reg;

    logic               acc_load, issue, out_load, out_free;
    logic               s_accept, cfg_we;
    logic [1:0]         in_ls;
    logic [IDX_W-1:0]   in_src, in_dst;
    logic [DATA_W-1:0]  in_val;
    logic [LC_W-1:0]    nl;
    logic [CNT_W-1:0]   wi, wo;
    logic               last_j, last_layer;
    logic [1:0]         src_bank, dst_bank, wl;

    logic               wt_we, bs_we, act_we, act_we_p, exp_we;
    logic [WADDR_W-1:0] wt_waddr, wt_raddr;
    logic [BADDR_W-1:0] bs_waddr, bs_raddr;
    logic [AADDR_W-1:0] act_waddr, act_raddr;
    logic [DATA_W-1:0]  act_wdata, act_wdata_p, wt_rdata, bs_rdata, act_rdata;
    logic [EXP_W-1:0]   exp_rdata;

    logic               ex_in_valid, ex_out_valid;
    logic [EXP_Y_W-1:0] ex_y;
    logic [EXP_W-1:0]   ex_e;
    div_req_t           div_req;
    logic               div_busy, div_done;
    logic [DIVN_W-1:0]  div_quot;

    logic signed [ACC_W-1:0] acc_rnd, acc_sh;
    logic [DATA_W-1:0]  q_round;
    logic [17:0]        sig_d;
    logic [DATA_W-1:0]  sig_val;

    function automatic logic [CNT_W-1:0] clamp_w(input logic [CNT_W-1:0] w);
        logic [CNT_W-1:0] r;
        r = w;
        if (w < 7'd1) r = 7'd1;
        if (w > 7'd64) r = 7'd64;
        return r;
    endfunction

    // configuration port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lc_reg <= 3'd3;
            w0_reg <= 7'd64;
            w1_reg <= 7'd32;
            w2_reg <= 7'd10;
            w3_reg <= 7'd10;
        end else if (cfg_we) begin
            case (paddr[4:2])
                REG_LAYERS: lc_reg <= pwdata[LC_W-1:0];
                REG_W0:     w0_reg <= pwdata[CNT_W-1:0];
                REG_W1:     w1_reg <= pwdata[CNT_W-1:0];
                REG_W2:     w2_reg <= pwdata[CNT_W-1:0];
                REG_W3:     w3_reg <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_LAYERS: prdata = {29'd0, lc_reg};
            REG_W0:     prdata = {25'd0, w0_reg};
            REG_W1:     prdata = {25'd0, w1_reg};
            REG_W2:     prdata = {25'd0, w2_reg};
            REG_W3:     prdata = {25'd0, w3_reg};
            default:    prdata = '0;
        endcase
    end

    // layer geometry
    always_comb begin
        nl = lc_reg;
        if (lc_reg < 3'd2) nl = 3'd2;
        if (lc_reg > 3'd4) nl = 3'd4;
        wl = 2'(l_reg - 3'd1);
        case (wl)
            2'd0:    wi = clamp_w(w0_reg);
            2'd1:    wi = clamp_w(w1_reg);
            2'd2:    wi = clamp_w(w2_reg);
            default: wi = clamp_w(w3_reg);
        endcase
        case (l_reg[1:0])
            2'd1:    wo = clamp_w(w1_reg);
            2'd2:    wo = clamp_w(w2_reg);
            2'd3:    wo = clamp_w(w3_reg);
            default: wo = clamp_w(w0_reg);
        endcase
        last_j     = {1'b0, j_reg} == wo - 7'd1;
        last_layer = l_reg == nl - 3'd1;
        dst_bank   = l_reg[0] ? BANK_A : BANK_B;
        src_bank   = (l_reg == 3'd1) ? BANK_IN : (l_reg[0] ? BANK_B : BANK_A);
    end

    // load requests
    assign s_tready = state_reg == S_IDLE;
    assign s_accept = s_tvalid && s_tready;
    assign in_ls    = s_tdata[1:0];
    assign in_src   = s_tdata[7:2];
    assign in_dst   = s_tdata[13:8];
    assign in_val   = s_tdata[29:14];

    assign wt_we     = s_accept && s_tuser == REQ_WEIGHT && in_ls != LAYER_NONE;
    assign wt_waddr  = {in_ls, in_src, in_dst};
    assign bs_we     = s_accept && s_tuser == REQ_BIAS && in_ls != LAYER_NONE;
    assign bs_waddr  = {in_ls, in_dst};
    assign act_we    = (s_accept && s_tuser == REQ_INPUT) || act_we_p;
    assign act_waddr = act_we_p ? {dst_bank, j_reg} : {BANK_IN, in_src};
    assign act_wdata = act_we_p ? act_wdata_p : in_val;
    assign wt_raddr  = {wl, i_reg, j_reg};
    assign bs_raddr  = {wl, j_reg};
    assign act_raddr = (state_reg == S_EXRD) ? {dst_bank, j_reg} : {src_bank, i_reg};

    mfi_ram #(.WIDTH(DATA_W), .DEPTH(WDEPTH)) u_wt (
        .aclk(aclk), .we(wt_we), .waddr(wt_waddr), .wdata(in_val),
        .raddr(wt_raddr), .rdata(wt_rdata)
    );
    mfi_ram #(.WIDTH(DATA_W), .DEPTH(BDEPTH)) u_bs (
        .aclk(aclk), .we(bs_we), .waddr(bs_waddr), .wdata(in_val),
        .raddr(bs_raddr), .rdata(bs_rdata)
    );
    mfi_ram #(.WIDTH(DATA_W), .DEPTH(ADEPTH)) u_act (
        .aclk(aclk), .we(act_we), .waddr(act_waddr), .wdata(act_wdata),
        .raddr(act_raddr), .rdata(act_rdata)
    );
    mfi_ram #(.WIDTH(EXP_W), .DEPTH(EDEPTH)) u_exp (
        .aclk(aclk), .we(exp_we), .waddr(j_reg), .wdata(ex_e),
        .raddr(j_reg), .rdata(exp_rdata)
    );

    mfi_expn u_expn (
        .aclk(aclk), .aresetn(aresetn), .in_valid(ex_in_valid), .y(ex_y),
        .out_valid(ex_out_valid), .e(ex_e)
    );

    mfi_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .req(div_req), .busy(div_busy),
        .done(div_done), .quot(div_quot)
    );

    // round accumulator to Q4.12 with saturation
    always_comb begin
        acc_rnd = acc_reg + ACC_W'(2048);
        acc_sh  = acc_rnd >>> FRAC_W;
        if (acc_sh > ACC_W'(32767)) begin
            q_round = 16'h7fff;
        end else if (acc_sh < -ACC_W'(32768)) begin
            q_round = 16'h8000;
        end else begin
            q_round = acc_sh[DATA_W-1:0];
        end
        sig_d   = 18'(ex_e) + 18'd65536;
        sig_val = q_reg[DATA_W-1] ? 16'(17'd4096 - div_quot[16:0]) : div_quot[DATA_W-1:0];
    end

    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next  = state_reg;
        l_next      = l_reg;
        j_next      = j_reg;
        i_next      = i_reg;
        q_next      = q_reg;
        mx_next     = mx_reg;
        sum_next    = sum_reg;
        p_next      = p_reg;
        acc_load    = 1'b0;
        issue       = 1'b0;
        act_we_p    = 1'b0;
        act_wdata_p = q_reg;
        ex_in_valid = 1'b0;
        ex_y        = '0;
        div_req     = '0;
        exp_we      = 1'b0;
        out_load    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_accept && s_tuser == REQ_INPUT && s_tlast) begin
                    l_next     = 3'd1;
                    j_next     = '0;
                    state_next = S_BIAS;
                end
            end
            S_BIAS: state_next = S_BIASW;
            S_BIASW: begin
                acc_load   = 1'b1;
                i_next     = '0;
                state_next = S_MAC;
            end
            S_MAC: begin
                issue  = 1'b1;
                i_next = i_reg + 1'b1;
                if ({1'b0, i_reg} == wi - 7'd1) state_next = S_DRAIN;
            end
            S_DRAIN: begin
                if (!rd_v_reg && !mul_v_reg) state_next = S_ROUND;
            end
            S_ROUND: begin
                q_next     = q_round;
                state_next = last_layer ? S_OWR : S_SIG0;
            end
            S_SIG0: begin
                ex_in_valid = 1'b1;
                ex_y        = q_reg[DATA_W-1] ? 17'd0 - {q_reg[DATA_W-1], q_reg}
                                              : {1'b0, q_reg};
                state_next  = S_SIGE;
            end
            S_SIGE: begin
                if (ex_out_valid) begin
                    div_req.start = 1'b1;
                    div_req.num   = DIVN_W'(33'd1 << 28) + DIVN_W'(sig_d >> 1);
                    div_req.den   = SUM_W'(sig_d);
                    state_next    = S_SIGD;
                end
            end
            S_SIGD: begin
                if (div_done) begin
                    act_we_p    = 1'b1;
                    act_wdata_p = sig_val;
                    state_next  = S_NEXT;
                end
            end
            S_OWR: begin
                act_we_p = 1'b1;
                if (j_reg == '0 || $signed(q_reg) > $signed(mx_reg)) mx_next = q_reg;
                state_next = S_NEXT;
            end
            S_NEXT: begin
                if (last_j) begin
                    j_next = '0;
                    if (last_layer) begin
                        sum_next   = '0;
                        state_next = S_EXRD;
                    end else begin
                        l_next     = l_reg + 3'd1;
                        state_next = S_BIAS;
                    end
                end else begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_BIAS;
                end
            end
            S_EXRD: state_next = S_EXW;
            S_EXW: begin
                ex_in_valid = 1'b1;
                ex_y        = {mx_reg[DATA_W-1], mx_reg} - {act_rdata[DATA_W-1], act_rdata};
                state_next  = S_EXE;
            end
            S_EXE: begin
                if (ex_out_valid) begin
                    exp_we   = 1'b1;
                    sum_next = sum_reg + SUM_W'(ex_e);
                    if (last_j) begin
                        j_next     = '0;
                        state_next = S_DVRD;
                    end else begin
                        j_next     = j_reg + 1'b1;
                        state_next = S_EXRD;
                    end
                end
            end
            S_DVRD: state_next = S_DVS;
            S_DVS: begin
                div_req.start = 1'b1;
                div_req.num   = {exp_rdata, 16'd0} + DIVN_W'(sum_reg >> 1);
                div_req.den   = sum_reg;
                state_next    = S_DVW;
            end
            S_DVW: begin
                if (div_done) begin
                    p_next     = (div_quot > DIVN_W'(65535)) ? 16'hffff : div_quot[DATA_W-1:0];
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (last_j) begin
                        j_next     = '0;
                        state_next = S_IDLE;
                    end else begin
                        j_next     = j_reg + 1'b1;
                        state_next = S_DVRD;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            l_reg       <= 3'd1;
            j_reg       <= '0;
            i_reg       <= '0;
            rd_v_reg    <= 1'b0;
            mul_v_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            l_reg     <= l_next;
            j_reg     <= j_next;
            i_reg     <= i_next;
            rd_v_reg  <= issue;
            mul_v_reg <= rd_v_reg;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        q_reg    <= q_next;
        mx_reg   <= mx_next;
        sum_reg  <= sum_next;
        p_reg    <= p_next;
        prod_reg <= $signed(act_rdata) * $signed(wt_rdata);
        if (acc_load) begin
            acc_reg <= {{(ACC_W-DATA_W-FRAC_W){bs_rdata[DATA_W-1]}}, bs_rdata, 12'd0};
        end else if (mul_v_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (out_load) begin
            m_idx_reg  <= j_reg;
            m_p_reg    <= p_reg;
            m_last_reg <= last_j;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'd0, m_p_reg, m_idx_reg};
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_busy)
        else $error("divider request while busy");
    a_mac_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_MAC |-> {1'b0, i_reg} < wi)
        else $error("mac index past layer width");
    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result without output state");
`endif

endmodule

// ===== test/tb_mlp_forward_inference_unit.sv =====
`timescale 1ns / 1ps

module tb_mlp_forward_inference_unit;
    import mfi_pkg::*;

    localparam int EXP_INT_TBL [12] = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60,
                                        22, 8, 3, 1};
    localparam int EXP_FRAC_TBL [17] = '{65536, 61565, 57835, 54331, 51039, 47947,
                                         45042, 42313, 39750, 37341, 35079, 32954,
                                         30957, 29081, 27319, 25664, 24109};
    localparam longint SAT61 = 64'sd1 <<< 61;

    typedef struct {
        logic [5:0]  idx;
        logic [15:0] prob;
        logic        last;
    } prob_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [31:0]       s_tdata = '0;
    logic [1:0]        s_tuser = '0;
    logic              s_tlast = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [23:0]       m_tdata;
    logic              m_tlast;

    mlp_forward_inference_unit dut (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // predictor state
    int          cfg_layers;
    int          cfg_width [4];
    shortint     weight_mem [3][64][64];
    bit          weight_ok [3][64][64];
    shortint     bias_mem [3][64];
    bit          bias_ok [3][64];
    shortint     input_mem [64];
    bit          input_ok [64];
    prob_t       expected_probs [$];
    int          errors = 0;
    int          results_seen = 0;
    int          passes = 0;
    int          requests = 0;
    bit          no_idle = 1'b0;

    function automatic int width_eff(int l);
        int w;
        w = cfg_width[l];
        return w < 1 ? 1 : (w > 64 ? 64 : w);
    endfunction

    function automatic int layers_eff();
        return cfg_layers < 2 ? 2 : (cfg_layers > 4 ? 4 : cfg_layers);
    endfunction

    function automatic longint neg_exp(longint y);
        longint n, r, k, t, f;
        n = y >>> 12;
        if (n >= 12)
            return 0;
        r = y & 4095;
        k = r >>> 8;
        t = r & 255;
        f = EXP_FRAC_TBL[k] - (((EXP_FRAC_TBL[k] - EXP_FRAC_TBL[k+1]) * t + 128) >>> 8);
        return (EXP_INT_TBL[n] * f + 32768) >>> 16;
    endfunction

    function automatic longint clamp_act(longint v);
        return v < -32768 ? -32768 : (v > 32767 ? 32767 : v);
    endfunction

    function automatic longint sigmoid_act(longint x);
        longint y, d, s;
        y = x < 0 ? -x : x;
        d = 65536 + neg_exp(y);
        s = (4096 * 65536 + d / 2) / d;
        if (x < 0)
            s = 4096 - s;
        return clamp_act(s);
    endfunction

    task automatic predict_pass();
        longint prev [64];
        longint next [64];
        longint acc, p, q, mx, sum;
        longint ev [64];
        int nl, wi, wo;
        prob_t r;
        nl = layers_eff();
        wo = 1;
        for (int i = 0; i < 64; i++)
            prev[i] = input_mem[i];
        for (int l = 1; l < nl; l++) begin
            wi = width_eff(l - 1);
            wo = width_eff(l);
            for (int j = 0; j < wo; j++) begin
                acc = longint'(bias_mem[l-1][j]) * 4096;
                for (int i = 0; i < wi; i++) begin
                    p = prev[i] * longint'(weight_mem[l-1][i][j]);
                    acc = acc + p;
                    if (acc > SAT61) acc = SAT61;
                    if (acc < -SAT61) acc = -SAT61;
                end
                q = clamp_act((acc + 2048) >>> 12);
                next[j] = (l < nl - 1) ? sigmoid_act(q) : q;
            end
            for (int j = 0; j < wo; j++)
                prev[j] = next[j];
        end
        mx = prev[0];
        for (int j = 1; j < wo; j++)
            if (prev[j] > mx) mx = prev[j];
        sum = 0;
        for (int j = 0; j < wo; j++) begin
            ev[j] = neg_exp(mx - prev[j]);
            sum += ev[j];
        end
        for (int j = 0; j < wo; j++) begin
            p = (ev[j] * 65536 + sum / 2) / sum;
            r.idx = j[5:0];
            r.prob = (p > 65535) ? 16'hFFFF : p[15:0];
            r.last = (j == wo - 1);
            expected_probs.push_back(r);
        end
        passes++;
    endtask

    task automatic send_req(logic [1:0] kind, logic [1:0] ls, logic [5:0] src,
                            logic [5:0] dst, logic [15:0] val, logic last);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tlast  <= last;
        s_tdata  <= {2'b00, val, dst, src, ls};
        do @(posedge aclk); while (!s_tready);
        requests++;
        case (kind)
            REQ_WEIGHT: if (ls != LAYER_NONE) begin
                weight_mem[ls][src][dst] = val;
                weight_ok[ls][src][dst] = 1'b1;
            end
            REQ_BIAS: if (ls != LAYER_NONE) begin
                bias_mem[ls][dst] = val;
                bias_ok[ls][dst] = 1'b1;
            end
            REQ_INPUT: begin
                input_mem[src] = val;
                input_ok[src] = 1'b1;
                if (last)
                    predict_pass();
            end
            default: ;
        endcase
    endtask

    function automatic logic [15:0] rand_value();
        if ($urandom_range(0, 7) == 0)
            return 16'($urandom_range(0, 65535));
        return 16'($signed($urandom_range(0, 4096)) - 2048);
    endfunction

    task automatic apb_write(logic [2:0] reg_idx, logic [31:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(reg_idx) << 2;
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == REG_LAYERS)
            cfg_layers = val & 7;
        else
            cfg_width[reg_idx - REG_W0] = val & 127;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_probs.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic set_network(int layers, int w0, int w1, int w2, int w3);
        wait_idle();
        apb_write(REG_LAYERS, layers);
        apb_write(REG_W0, w0);
        apb_write(REG_W1, w1);
        apb_write(REG_W2, w2);
        apb_write(REG_W3, w3);
    endtask

    // loads every parameter and input the current shape still lacks, then starts a pass
    task automatic run_pass();
        int nl, wi, wo;
        nl = layers_eff();
        for (int l = 1; l < nl; l++) begin
            wi = width_eff(l - 1);
            wo = width_eff(l);
            for (int i = 0; i < wi; i++)
                for (int j = 0; j < wo; j++)
                    if (!weight_ok[l-1][i][j])
                        send_req(REQ_WEIGHT, 2'(l - 1), 6'(i), 6'(j), rand_value(),
                                 1'($urandom_range(0, 1)));
            for (int j = 0; j < wo; j++)
                if (!bias_ok[l-1][j])
                    send_req(REQ_BIAS, 2'(l - 1), 6'($urandom_range(0, 63)), 6'(j),
                             rand_value(), 1'b0);
        end
        for (int i = 0; i < width_eff(0); i++)
            if (!input_ok[i])
                send_req(REQ_INPUT, 2'($urandom_range(0, 3)), 6'(i),
                         6'($urandom_range(0, 63)), rand_value(), 1'b0);
        send_req(REQ_INPUT, 2'($urandom_range(0, 3)), 6'($urandom_range(0, width_eff(0) - 1)),
                 6'($urandom_range(0, 63)), rand_value(), 1'b1);
    endtask

    // result side
    int stall_left = 0;
    always @(posedge aclk) begin
        prob_t e;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (m_tvalid && m_tready) begin
            results_seen++;
            if (expected_probs.size() == 0) begin
                errors++;
                $display("%0t: unexpected result idx=%0d prob=%0d last=%0b", $time,
                         m_tdata[5:0], m_tdata[21:6], m_tlast);
            end else begin
                e = expected_probs.pop_front();
                if (m_tdata[5:0] !== e.idx || m_tdata[21:6] !== e.prob ||
                    m_tlast !== e.last) begin
                    errors++;
                    $display("%0t: mismatch expected idx=%0d prob=%0d last=%0b, actual idx=%0d prob=%0d last=%0b",
                             $time, e.idx, e.prob, e.last, m_tdata[5:0], m_tdata[21:6],
                             m_tlast);
                end
            end
            stall_left = no_idle ? 0 : $urandom_range(0, 6);
            m_tready <= (stall_left == 0);
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= (stall_left == 0);
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic test_special_requests();
        set_network(2, 4, 3, 10, 10);
        send_req(REQ_WEIGHT, 2'd0, 6'd0, 6'd0, 16'h7FFF, 1'b1);
        send_req(REQ_WEIGHT, 2'd0, 6'd1, 6'd1, 16'h8000, 1'b0);
        send_req(REQ_WEIGHT, LAYER_NONE, 6'd63, 6'd63, 16'hFFFF, 1'b1);
        send_req(REQ_BIAS, LAYER_NONE, 6'd63, 6'd63, 16'h5555, 1'b1);
        send_req(REQ_BIAS, 2'd0, 6'd63, 6'd2, 16'h0000, 1'b1);
        send_req(2'd3, 2'd3, 6'h3F, 6'h3F, 16'hFFFF, 1'b1);
        send_req(REQ_INPUT, 2'd3, 6'd0, 6'h3F, 16'h7FFF, 1'b0);
        send_req(REQ_INPUT, 2'd1, 6'd1, 6'h2A, 16'h8000, 1'b0);
        send_req(REQ_INPUT, 2'd2, 6'd2, 6'h15, 16'h0000, 1'b0);
        run_pass();
        // stale inputs: only one element rewritten
        send_req(REQ_INPUT, 2'd0, 6'd3, 6'd0, 16'h1000, 1'b1);
    endtask

    task automatic test_single_output();
        set_network(2, 3, 1, 1, 1);
        run_pass();
    endtask

    task automatic test_register_clamps();
        set_network(0, 0, 2, 1, 1);
        run_pass();
        set_network(7, 2, 0, 1, 127);
        run_pass();
        set_network(3, 5, 4, 6, 2);
        run_pass();
    endtask

    task automatic test_largest_network();
        no_idle = 1'b1;
        set_network(4, 64, 1, 1, 1);
        run_pass();
        no_idle = 1'b0;
    endtask

    task automatic test_random_traffic();
        int start, n, pick;
        start = requests;
        while (requests - start < 60) begin
            set_network($urandom_range(2, 4), $urandom_range(1, 4), $urandom_range(1, 4),
                        $urandom_range(1, 4), $urandom_range(1, 4));
            no_idle = ($urandom_range(0, 3) == 0);
            n = $urandom_range(0, 12);
            for (int k = 0; k < n; k++) begin
                pick = $urandom_range(0, 9);
                if (pick < 4)
                    send_req(REQ_WEIGHT, 2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
                             6'($urandom_range(0, 63)), rand_value(),
                             1'($urandom_range(0, 1)));
                else if (pick < 6)
                    send_req(REQ_BIAS, 2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
                             6'($urandom_range(0, 63)), rand_value(),
                             1'($urandom_range(0, 1)));
                else if (pick < 9)
                    send_req(REQ_INPUT, 2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
                             6'($urandom_range(0, 63)), rand_value(), 1'b0);
                else
                    send_req(2'd3, 2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
                             6'($urandom_range(0, 63)), rand_value(),
                             1'($urandom_range(0, 1)));
            end
            run_pass();
            if ($urandom_range(0, 1))
                run_pass();
        end
        no_idle = 1'b0;
    endtask

    initial begin
        cfg_layers = 3;
        cfg_width = '{64, 32, 10, 10};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        test_special_requests();
        test_single_output();
        test_register_clamps();
        test_largest_network();
        test_random_traffic();
        wait_idle();
        repeat (100) @(posedge aclk);
        $display("Covered %0d requests, %0d forward passes, %0d probabilities checked",
                 requests, passes, results_seen);
        $display("Shapes from 2 to 4 layers, widths 1 to 64, with clamped register values");
        if (errors == 0 && expected_probs.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/mfi_pkg.sv
sv/mfi_ram.sv
sv/mfi_divider.sv
sv/mfi_expn.sv
sv/mlp_forward_inference_unit.sv
test/tb_mlp_forward_inference_unit.sv
